// ===== rtl/cls_pkg.sv =====
// Package for the command-line splitter: character codes, limits and the
// request/result structs passed between the top level and the splitter core.
// No dependencies.
`timescale 1ns / 1ps

package cls_pkg;

  localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  RUN_MAX      = 8'hFF;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_mark;
  } cls_item_t;

  typedef struct packed {
    logic [7:0]  lead_backslashes;
    logic        has_char;
    logic [7:0]  out_byte;
    logic        arg_end;
    logic        line_done;
    logic [15:0] args_so_far;
  } cls_result_t;

endpackage

// ===== rtl/cls_core.sv =====
// Splitter core: quote flag, backslash run, space skipping, argument count.
// Turns one request into at most one result, combinationally from the registered state.
// Depends on cls_pkg.
`timescale 1ns / 1ps

module cls_core
  import cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_fire,
  input  cls_item_t   item,
  output cls_result_t result,
  output logic        result_ok
);

  logic        quoting_r, quoting_nxt;
  logic [7:0]  run_r, run_nxt;
  logic        skip_r, skip_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic [15:0] count_r, count_nxt;

  logic        is_bs, is_q, is_sp, q_after_bs, sp_ends;
  logic [7:0]  lead;
  logic        has, aend, nonempty_set;
  logic [15:0] count_inc;

  always_comb begin
    is_bs      = (item.in_byte == CH_BACKSLASH);
    is_q       = (item.in_byte == CH_QUOTE);
    is_sp      = (item.in_byte == CH_SPACE);
    q_after_bs = is_q && (run_r != 8'd0);
    sp_ends    = is_sp && !quoting_r;

    quoting_nxt  = quoting_r;
    run_nxt      = run_r;
    skip_nxt     = skip_r;
    nonempty_nxt = nonempty_r;
    count_nxt    = count_r;

    lead         = 8'd0;
    has          = 1'b0;
    aend         = 1'b0;
    nonempty_set = 1'b0;
    count_inc    = (count_r != COUNT_MAX) ? count_r + 16'd1 : count_r;

    result           = '0;
    result_ok        = 1'b0;

    if (item.end_mark) begin
      lead         = run_r;
      nonempty_set = nonempty_r || (run_r != 8'd0);
      aend         = nonempty_set;
      result.lead_backslashes = lead;
      result.arg_end          = aend;
      result.line_done        = 1'b1;
      result.args_so_far      = aend ? count_inc : count_r;
      result_ok    = 1'b1;
      quoting_nxt  = 1'b0;
      run_nxt      = 8'd0;
      skip_nxt     = 1'b0;
      nonempty_nxt = 1'b0;
      count_nxt    = 16'd0;
    end else if (is_bs) begin
      if (run_r != RUN_MAX) begin
        run_nxt = run_r + 8'd1;
      end
      skip_nxt = 1'b0;
    end else if (!(sp_ends && skip_r)) begin
      if (q_after_bs) begin
        lead = {1'b0, run_r[7:1]};
        has  = run_r[0];
        if (!run_r[0]) begin
          quoting_nxt = !quoting_r;
        end
      end else begin
        lead = run_r;
        if (is_q) begin
          quoting_nxt = !quoting_r;
        end else if (sp_ends) begin
          aend = 1'b1;
        end else begin
          has = 1'b1;
        end
      end
      run_nxt  = 8'd0;
      skip_nxt = aend;
      if ((lead != 8'd0) || has) begin
        nonempty_nxt = 1'b1;
      end
      if (aend) begin
        count_nxt    = count_inc;
        nonempty_nxt = 1'b0;
      end
      result.lead_backslashes = lead;
      result.has_char         = has;
      result.out_byte         = has ? (q_after_bs ? CH_QUOTE : item.in_byte) : 8'd0;
      result.arg_end          = aend;
      result.args_so_far      = count_nxt;
      result_ok = (lead != 8'd0) || has || aend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quoting_r  <= 1'b0;
      run_r      <= 8'd0;
      skip_r     <= 1'b0;
      nonempty_r <= 1'b0;
      count_r    <= 16'd0;
    end else if (item_fire) begin
      quoting_r  <= quoting_nxt;
      run_r      <= run_nxt;
      skip_r     <= skip_nxt;
      nonempty_r <= nonempty_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

// ===== rtl/command_line_splitter.sv =====
// Top level of the command-line splitter: input register, splitter core,
// output register with stream handshakes on both sides.
// Depends on cls_pkg and cls_core.
//
//   channel | dir | tdata                              | tuser             | tlast
//   in_     | in  | [7:0] in_byte                      | -                 | end_mark
//   out_    | out | [7:0] lead, [15:8] byte, [31:16] n | [0] has, [1] end  | line_done
//
// One request per cycle while out_ accepts results; a request's result reaches
// out_ through the input register and then the result register.
// Requests that add nothing (a backslash, a swallowed space, a bare quote
// toggle) produce no result. Reset clears the splitter state and both stages.
// A stalled out_ holds its result; the input register keeps taking requests
// until it is itself full.
`timescale 1ns / 1ps

module command_line_splitter
  import cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_mark
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] lead_backslashes, [15:8] out_byte, [31:16] args_so_far
  output logic [1:0]  out_tuser,  // [0] has_char, [1] arg_end
  output logic        out_tlast   // line_done
);

  logic        s1_valid_r;
  cls_item_t   s1_item_r;
  logic        out_valid_r;
  cls_result_t out_res_r;

  logic        advance;
  logic        out_free;
  cls_result_t core_res;
  logic        core_ok;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || advance;

  cls_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (advance),
    .item      (s1_item_r),
    .result    (core_res),
    .result_ok (core_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.in_byte  <= in_tdata;
      s1_item_r.end_mark <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && core_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_ok) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.args_so_far, out_res_r.out_byte, out_res_r.lead_backslashes};
  assign out_tuser  = {out_res_r.arg_end, out_res_r.has_char};
  assign out_tlast  = out_res_r.line_done;

`ifndef SYNTHESIS
  a_done_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.line_done && out_res_r.has_char))
    else $error("line end carries a character");

  a_no_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.has_char) |-> (out_res_r.out_byte == 8'd0))
    else $error("out_byte nonzero without a character");

  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.line_done) |->
      ((out_res_r.lead_backslashes != 8'd0) || out_res_r.has_char || out_res_r.arg_end))
    else $error("empty result delivered");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register lost a stalled request");

  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.end_mark) |=>
      (!advance || s1_item_r.end_mark || core_res.args_so_far <= 16'd1))
    else $error("argument count not cleared after line end");
`endif

endmodule

// ===== tb/tb_command_line_splitter.sv =====
// Testbench for command_line_splitter: drives command-line bytes and end markers
// over the in_ stream, predicts each result in a local splitter model and checks
// out_ field by field. Depends on cls_pkg and the command_line_splitter RTL.
`timescale 1ns / 1ps

module tb_command_line_splitter;
  import cls_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // splitter state as predicted
  logic        in_quotes = 1'b0;
  logic [7:0]  pending_backslashes = '0;
  logic        swallow_spaces = 1'b0;
  logic        arg_has_content = 1'b0;
  logic [15:0] args_done = '0;

  cls_result_t expected_results[$];
  cls_result_t want;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;

  command_line_splitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void count_argument();
    if (args_done != COUNT_MAX) args_done = args_done + 16'd1;
    arg_has_content = 1'b0;
  endfunction

  // advance the predicted splitter by one request; return 1 when it yields a result
  function automatic bit split_request(input logic [7:0] ch, input logic end_mark,
                                       output cls_result_t res);
    logic [7:0] lead;
    logic       has;
    logic [7:0] emit;
    logic       ends_arg;
    res = '0;
    lead = '0;
    has = 1'b0;
    emit = '0;
    ends_arg = 1'b0;
    if (end_mark) begin
      lead = pending_backslashes;
      if (lead != 0) arg_has_content = 1'b1;
      if (arg_has_content) begin
        count_argument();
        ends_arg = 1'b1;
      end
      res.lead_backslashes = lead;
      res.arg_end = ends_arg;
      res.line_done = 1'b1;
      res.args_so_far = args_done;
      in_quotes = 1'b0;
      pending_backslashes = '0;
      swallow_spaces = 1'b0;
      arg_has_content = 1'b0;
      args_done = '0;
      return 1'b1;
    end
    if (ch == CH_BACKSLASH) begin
      if (pending_backslashes != RUN_MAX) pending_backslashes = pending_backslashes + 8'd1;
      swallow_spaces = 1'b0;
      return 1'b0;
    end
    if (ch == CH_SPACE && !in_quotes && swallow_spaces) return 1'b0;
    if (ch == CH_QUOTE && pending_backslashes != 0) begin
      lead = pending_backslashes >> 1;
      if (pending_backslashes[0]) begin
        has = 1'b1;
        emit = CH_QUOTE;
      end else begin
        in_quotes = !in_quotes;
      end
    end else begin
      lead = pending_backslashes;
      if (ch == CH_QUOTE) begin
        in_quotes = !in_quotes;
      end else if (ch == CH_SPACE && !in_quotes) begin
        ends_arg = 1'b1;
      end else begin
        has = 1'b1;
        emit = ch;
      end
    end
    pending_backslashes = '0;
    swallow_spaces = ends_arg;
    if (lead != 0 || has) arg_has_content = 1'b1;
    if (ends_arg) count_argument();
    res.lead_backslashes = lead;
    res.has_char = has;
    res.out_byte = emit;
    res.arg_end = ends_arg;
    res.args_so_far = args_done;
    return (lead != 0 || has || ends_arg);
  endfunction

  task automatic send_request(input logic [7:0] ch, input logic end_mark);
    cls_result_t res;
    while (!steady && $urandom_range(99) < 24) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= end_mark;
    do @(posedge clk); while (!in_tready);
    if (split_request(ch, end_mark, res)) expected_results.push_back(res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task automatic send_line_end();
    send_request(8'($urandom_range(255)), 1'b1);
  endtask

  // hold the sender until every expected result is back, then let the pipe empty
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_stream(input int unsigned n_items, input int unsigned noise_pct);
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < noise_pct) begin
        send_request(8'($urandom_range(255)), $urandom_range(15) == 0);
        sent++;
      end else if (pick < 5) begin
        send_line_end();
        sent++;
      end else if (pick < 25) begin
        run = $urandom_range(4, 1);
        repeat (run) send_request(CH_BACKSLASH, 1'b0);
        sent += run;
      end else if (pick < 40) begin
        send_request(CH_QUOTE, 1'b0);
        sent++;
      end else if (pick < 60) begin
        send_request(CH_SPACE, 1'b0);
        sent++;
      end else begin
        send_request(8'($urandom_range(8'h7E, 8'h21)), 1'b0);
        sent++;
      end
    end
    send_line_end();
  endtask

  task automatic test_words_and_spaces();
    send_text(" ab  \"\" ");
    send_line_end();
    send_line_end();
    drain_results();
  endtask

  task automatic test_escapes_and_quotes();
    send_text("\\\\\"x \\\\\\\"\\y\" z");
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_text("\"\\\\");
    send_line_end();
    drain_results();
  endtask

  task automatic test_long_backslash_runs();
    repeat (258) send_request(CH_BACKSLASH, 1'b0);
    send_request(CH_QUOTE, 1'b0);
    repeat (4) send_request(CH_BACKSLASH, 1'b0);
    send_line_end();
    drain_results();
  endtask

  task automatic test_full_rate();
    steady = 1'b1;
    send_random_stream(100, 10);
    drain_results();
    steady = 1'b0;
  endtask

  task automatic test_random_lines();
    send_random_stream(100, 15);
    drain_results();
    send_random_stream(100, 15);
    drain_results();
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $error("result with no request pending");
      end else begin
        want = expected_results.pop_front();
        check_field("lead_backslashes", 32'(want.lead_backslashes), 32'(out_tdata[7:0]));
        check_field("has_char", 32'(want.has_char), 32'(out_tuser[0]));
        check_field("out_byte", 32'(want.out_byte), 32'(out_tdata[15:8]));
        check_field("arg_end", 32'(want.arg_end), 32'(out_tuser[1]));
        check_field("line_done", 32'(want.line_done), 32'(out_tlast));
        check_field("args_so_far", 32'(want.args_so_far), 32'(out_tdata[31:16]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL command_line_splitter");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_words_and_spaces();
    test_escapes_and_quotes();
    test_long_backslash_runs();
    test_full_rate();
    test_random_lines();
    if (mismatches == 0) begin
      $display("PASS command_line_splitter");
    end else begin
      $display("FAIL command_line_splitter");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cls_pkg.sv
rtl/cls_core.sv
rtl/command_line_splitter.sv
tb/tb_command_line_splitter.sv
